[hw/rtl/mae_pkg.sv]
`default_nettype none

package mae_pkg;

    localparam int MAX_DIM     = 8;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 4;
    localparam int CNT_W       = ADDR_W + 2;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    // Wide enough for MAX_DIM full-scale products summed exactly.
    localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;

    localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_SUB    = 3'd1,
        MODE_MUL    = 3'd2,
        MODE_SCALE  = 3'd3,
        MODE_OFFSET = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_ROWS   = 3'd1,
        CFG_INNER  = 3'd2,
        CFG_COLS   = 3'd3,
        CFG_SCALAR = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STEP_ISSUE  = 2'd0,
        STEP_DRAIN0 = 2'd1,
        STEP_DRAIN1 = 2'd2,
        STEP_FIN    = 2'd3
    } t_step;

    typedef enum logic [1:0] {
        JMP_NONE      = 2'd0,
        JMP_K_MORE    = 2'd1,
        JMP_ELEM_MORE = 2'd2
    } t_jump;

    typedef struct packed {
        logic  rd_en;      // read both stores, advance k
        logic  emit;       // produce one result element
        logic  last_step;  // stop when the jump falls through
        t_jump jump;
        t_step target;
    } t_ucw;

    function automatic t_ucw ucode(input t_step step);
        t_ucw w;
        w = '{rd_en: 1'b0, emit: 1'b0, last_step: 1'b0, jump: JMP_NONE, target: STEP_ISSUE};
        unique case (step)
            STEP_ISSUE: begin
                w.rd_en  = 1'b1;
                w.jump   = JMP_K_MORE;
                w.target = STEP_ISSUE;
            end
            STEP_DRAIN0: begin
            end
            STEP_DRAIN1: begin
            end
            STEP_FIN: begin
                w.emit      = 1'b1;
                w.last_step = 1'b1;
                w.jump      = JMP_ELEM_MORE;
                w.target    = STEP_ISSUE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] raw);
        logic [DIM_W-1:0] d;
        if (raw == '0) begin
            d = DIM_W'(1);
        end else if (raw > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = raw;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/matrix_arithmetic_engine_top.sv]
// Channel   Direction  Handshake                    Payload
// element   in         start & !busy                i_element_value
// result    out        o_result_valid (one cycle)   o_result_value, o_result_row,
//                                                   o_result_column, o_last_element
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// Loading takes one cycle per element; busy stays low while A and B are loaded.
// The beat carrying the final element starts emission: busy is high while the
// result matrix is produced. Each result steps through ISSUE (repeated for each
// inner index in multiply mode), DRAIN0, DRAIN1 and FIN in the single
// multiplier/accumulator loop fed from one read port on each store. Reset
// (synchronous, active low) clears the config registers, load count and sequencer; the stores are not cleared.
// Results go out one beat per strobe and cannot be stalled.
`default_nettype none

module matrix_arithmetic_engine_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [31:0]          i_element_value,
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data,
    output logic                             o_result_valid,
    output logic signed [31:0]               o_result_value,
    output logic [2:0]                       o_result_row,
    output logic [2:0]                       o_result_column,
    output logic                             o_last_element
);

    localparam int AW   = mae_pkg::ADDR_W;
    localparam int IW   = mae_pkg::IDX_W;
    localparam int DW   = mae_pkg::DIM_W;
    localparam int CW   = mae_pkg::CNT_W;
    localparam int ACCW = mae_pkg::ACC_W;

    // configuration
    logic [2:0]         r_mode_raw;
    logic [DW-1:0]      r_rows_raw;
    logic [DW-1:0]      r_inner_raw;
    logic [DW-1:0]      r_cols_raw;
    logic signed [31:0] r_scalar;

    mae_pkg::t_mode     mode;
    logic [DW-1:0]      rows;
    logic [DW-1:0]      inner;
    logic [DW-1:0]      cols;
    logic [DW-1:0]      out_cols;
    logic [CW-1:0]      count_a;
    logic [CW-1:0]      count_b;
    logic [CW-1:0]      total;

    // loading
    logic [CW-1:0]      r_load_cnt;
    logic [CW-1:0]      load_cur;
    logic [CW-1:0]      load_nxt;
    logic [CW-1:0]      load_b_off;
    logic               accept;
    logic               launch;
    logic               wr_a;
    logic               wr_b;

    // stores
    logic signed [31:0] mem_a [mae_pkg::STORE_DEPTH];
    logic signed [31:0] mem_b [mae_pkg::STORE_DEPTH];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;
    logic [AW-1:0]      a_addr;
    logic [AW-1:0]      b_addr;
    logic [AW:0]        a_addr_w;
    logic [AW:0]        b_addr_w;

    // sequencer
    logic               r_running;
    mae_pkg::t_step     r_pc;
    mae_pkg::t_step     n_pc;
    mae_pkg::t_ucw      cw;
    logic               taken;
    logic               finish;
    logic [IW-1:0]      r_row;
    logic [IW-1:0]      r_col;
    logic [IW-1:0]      r_k;
    logic [IW-1:0]      k_last;
    logic [IW-1:0]      c_last;
    logic [IW-1:0]      r_last;
    logic               elem_last;

    // datapath
    logic               r_rd_vld;
    logic               r_prod_vld;
    logic signed [63:0] r_prod;
    logic signed [31:0] mul_b;
    logic signed [ACCW-1:0] r_acc;
    logic signed [ACCW-1:0] acc_sh;
    logic signed [32:0] sum33;
    logic signed [31:0] res_val;

    logic               r_res_vld;
    logic signed [31:0] r_res_val;
    logic [IW-1:0]      r_res_row;
    logic [IW-1:0]      r_res_col;
    logic               r_res_last;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_raw  <= mae_pkg::MODE_ADD;
            r_rows_raw  <= DW'(1);
            r_inner_raw <= DW'(1);
            r_cols_raw  <= DW'(1);
            r_scalar    <= 32'sh0001_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mae_pkg::CFG_MODE:   r_mode_raw  <= i_cfg_data[2:0];
                mae_pkg::CFG_ROWS:   r_rows_raw  <= i_cfg_data[DW-1:0];
                mae_pkg::CFG_INNER:  r_inner_raw <= i_cfg_data[DW-1:0];
                mae_pkg::CFG_COLS:   r_cols_raw  <= i_cfg_data[DW-1:0];
                mae_pkg::CFG_SCALAR: r_scalar    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // codes above offset act as offset
        if (r_mode_raw > mae_pkg::MODE_OFFSET) begin
            mode = mae_pkg::MODE_OFFSET;
        end else begin
            mode = mae_pkg::t_mode'(r_mode_raw);
        end
        rows     = mae_pkg::dim_clamp(r_rows_raw);
        inner    = mae_pkg::dim_clamp(r_inner_raw);
        cols     = mae_pkg::dim_clamp(r_cols_raw);
        out_cols = (mode == mae_pkg::MODE_MUL) ? cols : inner;
        count_a  = CW'(rows) * CW'(inner);
        priority case (mode)
            mae_pkg::MODE_ADD, mae_pkg::MODE_SUB: count_b = count_a;
            mae_pkg::MODE_MUL:                    count_b = CW'(inner) * CW'(cols);
            default:                              count_b = '0;
        endcase
        total = count_a + count_b;
    end

    // ---------------- loading ----------------
    assign accept     = start && !r_running;
    assign load_cur   = (r_load_cnt >= total) ? '0 : r_load_cnt;
    assign load_nxt   = load_cur + CW'(1);
    assign launch     = accept && (load_nxt == total);
    assign wr_a       = accept && (load_cur < count_a);
    assign wr_b       = accept && !(load_cur < count_a);
    assign load_b_off = load_cur - count_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (i_cfg_we && (i_cfg_index <= mae_pkg::CFG_SCALAR)) begin
            r_load_cnt <= '0;
        end else if (accept) begin
            r_load_cnt <= launch ? '0 : load_nxt;
        end
    end

    // ---------------- stores ----------------
    always_comb begin
        a_addr_w = (AW+1)'(r_row) * (AW+1)'(inner)
                 + (AW+1)'((mode == mae_pkg::MODE_MUL) ? r_k : r_col);
        if (mode == mae_pkg::MODE_MUL) begin
            b_addr_w = (AW+1)'(r_k) * (AW+1)'(cols) + (AW+1)'(r_col);
        end else begin
            b_addr_w = (AW+1)'(r_row) * (AW+1)'(inner) + (AW+1)'(r_col);
        end
        a_addr = a_addr_w[AW-1:0];
        b_addr = b_addr_w[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[load_cur[AW-1:0]] <= i_element_value;
        end
        if (cw.rd_en && r_running) begin
            r_rd_a <= mem_a[a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[load_b_off[AW-1:0]] <= i_element_value;
        end
        if (cw.rd_en && r_running) begin
            r_rd_b <= mem_b[b_addr];
        end
    end

    // ---------------- sequencer ----------------
    assign cw        = mae_pkg::ucode(r_pc);
    assign k_last    = (mode == mae_pkg::MODE_MUL) ? IW'(inner - DW'(1)) : '0;
    assign c_last    = IW'(out_cols - DW'(1));
    assign r_last    = IW'(rows - DW'(1));
    assign elem_last = (r_row == r_last) && (r_col == c_last);

    always_comb begin
        unique case (cw.jump)
            mae_pkg::JMP_K_MORE:    taken = (r_k != k_last);
            mae_pkg::JMP_ELEM_MORE: taken = !elem_last;
            default:                taken = 1'b0;
        endcase
        n_pc   = taken ? cw.target : mae_pkg::t_step'(r_pc + 2'd1);
        finish = cw.last_step && !taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_pc      <= mae_pkg::STEP_ISSUE;
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
        end else if (!r_running) begin
            r_pc <= mae_pkg::STEP_ISSUE;
            if (launch) begin
                r_running <= 1'b1;
                r_row     <= '0;
                r_col     <= '0;
                r_k       <= '0;
            end
        end else begin
            r_pc <= finish ? mae_pkg::STEP_ISSUE : n_pc;
            if (finish) begin
                r_running <= 1'b0;
            end
            if (cw.rd_en) begin
                r_k <= (r_k == k_last) ? '0 : r_k + IW'(1);
            end
            if (cw.emit) begin
                if (r_col == c_last) begin
                    r_col <= '0;
                    r_row <= r_row + IW'(1);
                end else begin
                    r_col <= r_col + IW'(1);
                end
            end
        end
    end

    // ---------------- multiply / accumulate ----------------
    assign mul_b = (mode == mae_pkg::MODE_SCALE) ? r_scalar : r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= cw.rd_en && r_running;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= r_rd_a * mul_b;
        end
        // pipeline is drained at FIN and at launch, so no product is lost
        if (launch || (cw.emit && r_running)) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACCW'(r_prod);
        end
    end

    always_comb begin
        acc_sh = r_acc >>> mae_pkg::FRAC_BITS;
        priority case (mode)
            mae_pkg::MODE_SUB:    sum33 = 33'(r_rd_a) - 33'(r_rd_b);
            mae_pkg::MODE_OFFSET: sum33 = 33'(r_rd_a) + 33'(r_scalar);
            default:              sum33 = 33'(r_rd_a) + 33'(r_rd_b);
        endcase
        if ((mode == mae_pkg::MODE_MUL) || (mode == mae_pkg::MODE_SCALE)) begin
            if (acc_sh > ACCW'(mae_pkg::INT32_MAX)) begin
                res_val = mae_pkg::INT32_MAX;
            end else if (acc_sh < ACCW'(mae_pkg::INT32_MIN)) begin
                res_val = mae_pkg::INT32_MIN;
            end else begin
                res_val = acc_sh[31:0];
            end
        end else begin
            if (sum33 > 33'(mae_pkg::INT32_MAX)) begin
                res_val = mae_pkg::INT32_MAX;
            end else if (sum33 < 33'(mae_pkg::INT32_MIN)) begin
                res_val = mae_pkg::INT32_MIN;
            end else begin
                res_val = sum33[31:0];
            end
        end
    end

    // ---------------- result beat ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= cw.emit && r_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw.emit && r_running) begin
            r_res_val  <= res_val;
            r_res_row  <= r_row;
            r_res_col  <= r_col;
            r_res_last <= elem_last;
        end
    end

    assign busy            = r_running;
    assign o_result_valid  = r_res_vld;
    assign o_result_value  = r_res_val;
    assign o_result_row    = r_res_row;
    assign o_result_column = r_res_col;
    assign o_last_element  = r_res_vld && r_res_last;

`ifndef NO_ASSERTIONS
    a_res_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_running))
        else $error("result beat without a running sequence");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_element |-> !busy)
        else $error("last result beat while still busy");

    a_pc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_pc == mae_pkg::STEP_ISSUE))
        else $error("sequencer step advanced while idle");

    a_drained_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running && cw.emit) |-> (!r_rd_vld && !r_prod_vld))
        else $error("product still in flight at result step");
`endif

endmodule

`default_nettype wire

[test/tb_matrix_arithmetic_engine_top.sv]
`timescale 1ns / 100ps

module tb_matrix_arithmetic_engine_top;

    localparam int          RANDOM_ITEMS       = 156;
    localparam int          SETTLE_CYCLES      = 4;
    localparam int          TAIL_CYCLES        = 20;
    // longest legal quiet stretch is the longest sender gap that pick_gap returns
    localparam int          STALL_LIMIT        = 2000;
    localparam logic [2:0]  CFG_SPARE_FIRST    = 3'd5;
    localparam logic [2:0]  CFG_SPARE_LAST     = 3'd7;
    localparam logic [2:0]  MODE_RESERVED_LAST = 3'd7;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         row;
        logic [2:0]         column;
        logic               last;
    } t_result_beat;

    class t_result_tracker;
        logic [2:0]         mode_reg;
        logic [3:0]         rows_reg;
        logic [3:0]         inner_reg;
        logic [3:0]         cols_reg;
        logic signed [31:0] scalar_reg;
        logic signed [31:0] store_a [mae_pkg::STORE_DEPTH];
        logic signed [31:0] store_b [mae_pkg::STORE_DEPTH];
        int unsigned        load_cnt;
        t_result_beat       pending_beats [$];
        int unsigned        mismatch_count;
        int unsigned        beats_checked;

        function new();
            mode_reg       = mae_pkg::MODE_ADD;
            rows_reg       = 4'd1;
            inner_reg      = 4'd1;
            cols_reg       = 4'd1;
            scalar_reg     = 32'sh0001_0000;
            load_cnt       = 0;
            mismatch_count = 0;
            beats_checked  = 0;
        endfunction

        function int unsigned fold_dim(logic [3:0] raw);
            if (raw == 4'd0) begin
                return 1;
            end else if (raw > mae_pkg::MAX_DIM) begin
                return mae_pkg::MAX_DIM;
            end
            return raw;
        endfunction

        function mae_pkg::t_mode active_mode();
            return (mode_reg > mae_pkg::MODE_OFFSET) ? mae_pkg::MODE_OFFSET
                                                     : mae_pkg::t_mode'(mode_reg);
        endfunction

        function int unsigned a_length();
            return fold_dim(rows_reg) * fold_dim(inner_reg);
        endfunction

        function int unsigned b_length();
            mae_pkg::t_mode m;
            m = active_mode();
            if (m == mae_pkg::MODE_ADD || m == mae_pkg::MODE_SUB) begin
                return a_length();
            end else if (m == mae_pkg::MODE_MUL) begin
                return fold_dim(inner_reg) * fold_dim(cols_reg);
            end
            return 0;
        endfunction

        function int unsigned load_length();
            return a_length() + b_length();
        endfunction

        function logic signed [31:0] clip32(logic signed [71:0] v);
            if (v > 72'sh00_7FFF_FFFF) begin
                return mae_pkg::INT32_MAX;
            end else if (v < -72'sh00_8000_0000) begin
                return mae_pkg::INT32_MIN;
            end
            return v[31:0];
        endfunction

        function void apply_config(logic [2:0] idx, logic [31:0] data);
            case (idx)
                mae_pkg::CFG_MODE:   mode_reg   = data[2:0];
                mae_pkg::CFG_ROWS:   rows_reg   = data[3:0];
                mae_pkg::CFG_INNER:  inner_reg  = data[3:0];
                mae_pkg::CFG_COLS:   cols_reg   = data[3:0];
                mae_pkg::CFG_SCALAR: scalar_reg = data;
                default:             return;
            endcase
            load_cnt = 0;
        endfunction

        function void take_element(logic signed [31:0] v);
            mae_pkg::t_mode     m;
            int unsigned        rows;
            int unsigned        inner;
            int unsigned        cols;
            int unsigned        n_a;
            int unsigned        n_total;
            int unsigned        out_cols;
            logic signed [31:0] a;
            logic signed [31:0] b;
            logic signed [71:0] acc;
            t_result_beat       beat;
            m        = active_mode();
            rows     = fold_dim(rows_reg);
            inner    = fold_dim(inner_reg);
            cols     = fold_dim(cols_reg);
            n_a      = a_length();
            n_total  = load_length();
            out_cols = (m == mae_pkg::MODE_MUL) ? cols : inner;
            if (load_cnt >= n_total) begin
                load_cnt = 0;
            end
            if (load_cnt < n_a) begin
                store_a[load_cnt] = v;
            end else begin
                store_b[load_cnt - n_a] = v;
            end
            load_cnt++;
            if (load_cnt < n_total) begin
                return;
            end
            load_cnt = 0;
            for (int unsigned r = 0; r < rows; r++) begin
                for (int unsigned c = 0; c < out_cols; c++) begin
                    a = store_a[(r * inner + c) % mae_pkg::STORE_DEPTH];
                    b = store_b[(r * inner + c) % mae_pkg::STORE_DEPTH];
                    case (m)
                        mae_pkg::MODE_MUL: begin
                            acc = '0;
                            for (int unsigned k = 0; k < inner; k++) begin
                                acc = acc + 72'(store_a[r * inner + k])
                                          * 72'(store_b[k * cols + c]);
                            end
                            beat.value = clip32(acc >>> mae_pkg::FRAC_BITS);
                        end
                        mae_pkg::MODE_SCALE: begin
                            acc        = 72'(a) * 72'(scalar_reg);
                            beat.value = clip32(acc >>> mae_pkg::FRAC_BITS);
                        end
                        mae_pkg::MODE_OFFSET: beat.value = clip32(72'(a) + 72'(scalar_reg));
                        mae_pkg::MODE_SUB:    beat.value = clip32(72'(a) - 72'(b));
                        default:              beat.value = clip32(72'(a) + 72'(b));
                    endcase
                    beat.row    = r[2:0];
                    beat.column = c[2:0];
                    beat.last   = (r == rows - 1) && (c == out_cols - 1);
                    pending_beats.push_back(beat);
                end
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        endfunction

        function void check_result(logic signed [31:0] value, logic [2:0] row,
                                   logic [2:0] column, logic last);
            t_result_beat want;
            beats_checked++;
            if (pending_beats.size() == 0) begin
                report("unexpected beat, value", '0, value);
                return;
            end
            want = pending_beats.pop_front();
            if (value !== want.value) report("value", want.value, value);
            if (row !== want.row) report("row", 32'(want.row), 32'(row));
            if (column !== want.column) report("column", 32'(want.column), 32'(column));
            if (last !== want.last) report("last", 32'(want.last), 32'(last));
        endfunction

        function int unsigned pending();
            return pending_beats.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_element_value;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               o_result_valid;
    logic signed [31:0] o_result_value;
    logic [2:0]         o_result_row;
    logic [2:0]         o_result_column;
    logic               o_last_element;

    t_result_tracker    tracker;
    int unsigned        elements_in;
    int unsigned        cfg_writes;
    int unsigned        stall_cycles;

    matrix_arithmetic_engine_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_element_value (i_element_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_result_value  (o_result_value),
        .o_result_row    (o_result_row),
        .o_result_column (o_result_column),
        .o_last_element  (o_last_element)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid === 1'b1) begin
                tracker.check_result(o_result_value, o_result_row, o_result_column,
                                     o_last_element);
            end
            if (i_cfg_we) begin
                tracker.apply_config(i_cfg_index, i_cfg_data);
                cfg_writes++;
            end
            if (start && busy === 1'b0) begin
                tracker.take_element(i_element_value);
                elements_in++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_result_valid === 1'b1 || i_cfg_we || (start && busy === 1'b0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // start stays high after the accepting edge; the next call sets it again
    task automatic send_element(input logic [31:0] v);
        @(negedge i_clk);
        start           <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'($signed($urandom_range(0, 524288)) - 262144);
            4, 5, 6, 7: return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    // junk in the unused upper bits now and then
    function automatic logic [31:0] dim_word();
        logic [31:0] upper;
        logic [3:0]  d;
        int          r;
        upper = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        r     = $urandom_range(0, 19);
        if (r == 0) begin
            d = 4'd0;
        end else if (r == 1) begin
            d = 4'($urandom_range(mae_pkg::MAX_DIM + 1, 15));
        end else if (r < 4) begin
            d = 4'(mae_pkg::MAX_DIM);
        end else begin
            d = 4'($urandom_range(1, 3));
        end
        return {upper[31:4], d};
    endfunction

    function automatic logic [31:0] mode_word();
        logic [31:0] upper;
        int          r;
        upper = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        r     = $urandom_range(0, 15);
        if (r < 14) begin
            return {upper[31:3], 3'(r % 5)};
        end
        return {upper[31:3], 3'($urandom_range(mae_pkg::MODE_OFFSET + 1, MODE_RESERVED_LAST))};
    endfunction

    initial begin
        int          random_items;
        int          phases;
        int          loads;
        int unsigned len;
        bit          quiet;
        bit          broken;
        int unsigned total_fail;
        tracker         = new();
        elements_in     = 0;
        cfg_writes      = 0;
        stall_cycles    = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_element_value = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        random_items    = 0;
        phases          = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: 1x1 add, both operands at full scale
        send_element(32'h7FFF_FFFF);
        send_element(32'h7FFF_FFFF);
        write_reg(mae_pkg::CFG_MODE, 32'(mae_pkg::MODE_SUB));
        send_element(32'h8000_0000);
        send_element(32'h0000_0001);
        // zero row count folds to one; products overflow the 32-bit range
        write_reg(mae_pkg::CFG_MODE, 32'(mae_pkg::MODE_MUL));
        write_reg(mae_pkg::CFG_ROWS, 32'd0);
        write_reg(mae_pkg::CFG_INNER, 32'd2);
        write_reg(mae_pkg::CFG_COLS, 32'd1);
        repeat (4) send_element(32'h8000_0000);
        write_reg(mae_pkg::CFG_MODE, 32'(mae_pkg::MODE_SCALE));
        write_reg(mae_pkg::CFG_ROWS, 32'd1);
        write_reg(mae_pkg::CFG_INNER, 32'd1);
        write_reg(mae_pkg::CFG_SCALAR, 32'h8000_0000);
        send_element(32'h8000_0000);
        write_reg(mae_pkg::CFG_SCALAR, 32'h0000_0001);
        send_element(32'hFFFF_FFFF);
        write_reg(mae_pkg::CFG_MODE, 32'(mae_pkg::MODE_OFFSET));
        write_reg(mae_pkg::CFG_SCALAR, 32'h7FFF_FFFF);
        send_element(32'h0000_0001);
        // reserved mode acts as offset
        write_reg(mae_pkg::CFG_MODE, 32'(MODE_RESERVED_LAST));
        write_reg(mae_pkg::CFG_SCALAR, 32'h8000_0000);
        send_element(32'h8000_0000);
        // oversize row count clamps to eight rows
        write_reg(mae_pkg::CFG_ROWS, {28'hFFF_FFFF, 4'd9});
        repeat (8) send_element(pick_value());
        write_reg(CFG_SPARE_FIRST, 32'hFFFF_FFFF);
        write_reg(mae_pkg::CFG_MODE, 32'(mae_pkg::MODE_ADD));
        write_reg(mae_pkg::CFG_ROWS, 32'd1);
        // a register write mid-load restarts the load
        send_element(32'h1234_5678);
        write_reg(mae_pkg::CFG_COLS, 32'd15);
        send_element(32'h0001_0000);
        send_element(32'hFFFF_0000);

        while (random_items < RANDOM_ITEMS) begin
            phases++;
            quiet = ($urandom_range(0, 3) == 0);
            write_reg(mae_pkg::CFG_MODE, mode_word());
            if ($urandom_range(0, 1)) write_reg(mae_pkg::CFG_ROWS, dim_word());
            if ($urandom_range(0, 1)) write_reg(mae_pkg::CFG_INNER, dim_word());
            if ($urandom_range(0, 1)) write_reg(mae_pkg::CFG_COLS, dim_word());
            if ($urandom_range(0, 2) == 0) write_reg(mae_pkg::CFG_SCALAR, pick_value());
            if ($urandom_range(0, 19) == 0) begin
                write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
            end
            loads  = $urandom_range(1, 3);
            broken = 1'b0;
            for (int j = 0; j < loads && !broken && random_items < RANDOM_ITEMS; j++) begin
                len = tracker.load_length();
                if (len > 1 && $urandom_range(0, 9) == 0) begin
                    len    = $urandom_range(1, len - 1);
                    broken = 1'b1;
                end
                for (int unsigned k = 0; k < len && random_items < RANDOM_ITEMS; k++) begin
                    send_element(pick_value());
                    random_items++;
                    pause(pick_gap(quiet));
                end
                if ($urandom_range(0, 5) == 0) drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        total_fail = tracker.mismatch_count + tracker.pending();
        if (tracker.pending() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, tracker.pending());
        end
        $display("Ran %0d elements through %0d register writes and %0d random phases,",
                 elements_in, cfg_writes, phases);
        $display("checking %0d result beats across add, sub, mul, scale and offset.",
                 tracker.beats_checked);
        if (total_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
